>>> src/ground_plane_projection_mapper_unit_macros.svh
// Assertion macros for the ground plane projection mapper.
// Included by the modules that check their own logic; no other dependencies.
`ifndef GROUND_PLANE_PROJECTION_MAPPER_UNIT_MACROS_SVH
`define GROUND_PLANE_PROJECTION_MAPPER_UNIT_MACROS_SVH

// Consequence must hold in the same cycle as the antecedent.
`define GPPM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define GPPM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/gppm_pkg.sv
// Shared constants and types for the ground plane projection mapper.
// No dependencies; used by the division cell and the top level.
package gppm_pkg;

  // Default bird's-eye output resolution.
  localparam int unsigned OUT_RES_DEFAULT = 800;

  // Quotient bits per division: one overflow bit and twelve result bits.
  localparam int unsigned QUOT_W = 13;

  // Numerator width for the default resolution.
  localparam int unsigned NUM_W_DEFAULT = 51;

  // Width of the grid times span products.
  localparam int unsigned GRID_PROD_W = 28;

  // Output column mirror mode.
  localparam logic MODE_MIRROR = 1'b1;

  // Register reset values.
  localparam logic signed [15:0] PITCH_COS_RESET = -16'sd10027;
  localparam logic signed [15:0] PITCH_SIN_RESET = 16'sd31189;
  localparam logic [11:0] FOCAL_SCALE_RESET = 12'd1000;
  localparam logic [12:0] IMAGE_WIDTH_RESET = 13'd640;
  localparam logic [12:0] IMAGE_HEIGHT_RESET = 13'd480;
  localparam logic [15:0] GROUND_SPAN_X_RESET = 16'd30720;
  localparam logic [15:0] GROUND_SPAN_Y_RESET = 16'd30720;
  localparam logic [11:0] MOUNT_HEIGHT_RESET = 12'd448;

  // Register map, word index.
  typedef enum logic [2:0] {
    REG_PITCH_COS    = 3'd0,
    REG_PITCH_SIN    = 3'd1,
    REG_FOCAL_SCALE  = 3'd2,
    REG_IMAGE_WIDTH  = 3'd3,
    REG_IMAGE_HEIGHT = 3'd4,
    REG_SPAN_X       = 3'd5,
    REG_SPAN_Y       = 3'd6,
    REG_MOUNT_HEIGHT = 3'd7
  } gppm_reg_e;

endpackage

>>> src/gppm_div_cell.sv
// One restoring division step: a cell of the perspective divide chain.
// Depends on gppm_pkg for its default widths.
module gppm_div_cell #(
  parameter int unsigned NumW  = gppm_pkg::NUM_W_DEFAULT,
  parameter int unsigned QuotW = gppm_pkg::QUOT_W
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NumW-1:0]  rem_i,
  input  logic [NumW-1:0]  div_i,
  input  logic [QuotW-1:0] quot_i,
  output logic [NumW-1:0]  rem_o,
  output logic [NumW-1:0]  div_o,
  output logic [QuotW-1:0] quot_o
);
  import gppm_pkg::*;

  logic             fits;
  logic [NumW-1:0]  rem_d, rem_q;
  logic [NumW-1:0]  div_d, div_q;
  logic [QuotW-1:0] quot_d, quot_q;

  // Trial subtraction; the divisor halves for the next cell.
  always_comb begin
    fits   = rem_i >= div_i;
    rem_d  = fits ? rem_i - div_i : rem_i;
    div_d  = div_i >> 1;
    quot_d = {quot_i[QuotW-2:0], fits};
  end

  // Hand the partial result on to the neighbouring cell.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      div_q  <= div_d;
      quot_q <= quot_d;
    end
  end

  assign rem_o  = rem_q;
  assign div_o  = div_q;
  assign quot_o = quot_q;

endmodule

>>> src/ground_plane_projection_mapper_unit.sv
// Ground plane projection mapper: bird's-eye grid pixel to camera image sample.
// Depends on gppm_pkg, gppm_div_cell and the assertion macro header.
//
// Usage: the input channel (in_valid_i, in_stall_o) carries one grid beat
// (grid_x_i, grid_y_i, mode_i); the output channel (out_valid_o, out_stall_i)
// returns one result beat per input beat, in order. A beat moves at a rising
// edge where valid is high and stall is low.
// Throughput is one beat per cycle while the output does not stall. The
// accepting edge loads the first of seven arithmetic stages (grid scaling
// by a reciprocal, pitch rotation, numerator build, magnitude split); a
// chain of thirteen division cells follows that each resolve one quotient
// bit per cycle while the pipeline moves, then the output register.
// A skid register sits behind the output register. When the receiver stalls,
// the result in flight goes into the skid register and in_stall_o rises in
// the next cycle; the pipeline holds until the skid register drains.
// Reset clears all valid flags and loads the register defaults. The user
// writes the APB registers only while the block is idle; the block does not enforce it.
`include "ground_plane_projection_mapper_unit_macros.svh"

module ground_plane_projection_mapper_unit #(
  parameter int unsigned OUT_RES = gppm_pkg::OUT_RES_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [11:0] grid_x_i,
  input  logic [11:0] grid_y_i,
  input  logic        mode_i,
  // Output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        sample_valid_o,
  output logic [11:0] source_col_o,
  output logic [11:0] source_row_o,
  output logic [11:0] dest_row_o,
  output logic [11:0] dest_col_o
);
  import gppm_pkg::*;

  // Derived widths.
  localparam int unsigned ResW   = $clog2(OUT_RES);
  localparam int unsigned ProdW  = GRID_PROD_W;
  localparam int unsigned HalfW  = ProdW / 2;
  localparam int unsigned RecipS = ProdW + ResW;
  localparam int unsigned RecipW = ProdW + 1;
  localparam int unsigned PartW  = HalfW + RecipW;
  localparam int unsigned SumW   = ProdW + RecipW;
  localparam int unsigned QW     = ProdW + 1 - ResW;
  localparam int unsigned XW     = QW + 1;
  localparam int unsigned ZW     = ((QW + 17 > 29) ? QW + 17 : 29) + 1;
  localparam int unsigned NW     = ((QW + 29 > ZW + 13) ? QW + 29 : ZW + 13) + 1;
  localparam int unsigned NST    = 7 + QUOT_W;
  localparam logic [RecipW-1:0] Recip =
    RecipW'(((64'd1 << RecipS) + 64'(OUT_RES) - 64'd1) / 64'(OUT_RES));
  localparam logic [11:0] LastIdx = 12'(OUT_RES - 1);

  typedef struct packed {
    logic [11:0] dest_row;
    logic [11:0] dest_col;
    logic        z_pos;
    logic        col_neg;
    logic        row_neg;
  } side_t;

  typedef struct packed {
    logic        sample_valid;
    logic [11:0] source_col;
    logic [11:0] source_row;
    logic [11:0] dest_row;
    logic [11:0] dest_col;
  } res_t;

  // Configuration registers.
  logic signed [15:0] pitch_cos_q, pitch_sin_q;
  logic [11:0]        focal_q, mount_height_q;
  logic [12:0]        image_width_q, image_height_q;
  logic [15:0]        span_x_q, span_y_q;
  gppm_reg_e          wr_idx, rd_idx;

  always_comb begin
    wr_idx = gppm_reg_e'(paddr[4:2]);
    rd_idx = gppm_reg_e'(paddr[4:2]);
  end

  assign pready = 1'b1;

  // Register writes on the access phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pitch_cos_q    <= PITCH_COS_RESET;
      pitch_sin_q    <= PITCH_SIN_RESET;
      focal_q        <= FOCAL_SCALE_RESET;
      image_width_q  <= IMAGE_WIDTH_RESET;
      image_height_q <= IMAGE_HEIGHT_RESET;
      span_x_q       <= GROUND_SPAN_X_RESET;
      span_y_q       <= GROUND_SPAN_Y_RESET;
      mount_height_q <= MOUNT_HEIGHT_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (wr_idx)
        REG_PITCH_COS:    pitch_cos_q    <= pwdata[15:0];
        REG_PITCH_SIN:    pitch_sin_q    <= pwdata[15:0];
        REG_FOCAL_SCALE:  focal_q        <= pwdata[11:0];
        REG_IMAGE_WIDTH:  image_width_q  <= pwdata[12:0];
        REG_IMAGE_HEIGHT: image_height_q <= pwdata[12:0];
        REG_SPAN_X:       span_x_q       <= pwdata[15:0];
        REG_SPAN_Y:       span_y_q       <= pwdata[15:0];
        REG_MOUNT_HEIGHT: mount_height_q <= pwdata[11:0];
        default:          pitch_cos_q    <= pitch_cos_q;
      endcase
    end
  end

  // Register read-back, zero extended.
  always_comb begin
    unique case (rd_idx)
      REG_PITCH_COS:    prdata = {16'b0, pitch_cos_q};
      REG_PITCH_SIN:    prdata = {16'b0, pitch_sin_q};
      REG_FOCAL_SCALE:  prdata = 32'(focal_q);
      REG_IMAGE_WIDTH:  prdata = 32'(image_width_q);
      REG_IMAGE_HEIGHT: prdata = 32'(image_height_q);
      REG_SPAN_X:       prdata = 32'(span_x_q);
      REG_SPAN_Y:       prdata = 32'(span_y_q);
      REG_MOUNT_HEIGHT: prdata = 32'(mount_height_q);
      default:          prdata = '0;
    endcase
  end

  // Pipeline control: every stage moves while the skid register is empty.
  logic           en;
  logic [NST:1]   v_q;
  side_t          side_q [1:NST];
  side_t          side_d [1:NST];
  logic           skid_v_q, out_v_q, out_free;

  assign en         = !skid_v_q;
  assign in_stall_o = skid_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NST-1:1], in_valid_i};
    end
  end

  // Stage 1: grid coordinate times ground span; destination indices.
  logic [ProdW-1:0] px_q, py_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      px_q <= ProdW'(grid_x_i) * ProdW'(span_x_q);
      py_q <= ProdW'(grid_y_i) * ProdW'(span_y_q);
    end
  end

  // Stage 2: reciprocal multiply of each product in two halves.
  logic [PartW-1:0] pxh_q, pxl_q, pyh_q, pyl_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      pxh_q <= PartW'(px_q[ProdW-1:HalfW]) * PartW'(Recip);
      pxl_q <= PartW'(px_q[HalfW-1:0]) * PartW'(Recip);
      pyh_q <= PartW'(py_q[ProdW-1:HalfW]) * PartW'(Recip);
      pyl_q <= PartW'(py_q[HalfW-1:0]) * PartW'(Recip);
    end
  end

  // Stage 3: quotients by the output resolution, lateral offset removed.
  logic [SumW-1:0]      sum_x, sum_y;
  logic [XW-1:0]        xg_d;
  logic signed [XW-1:0] xg_q;
  logic [QW-1:0]        yg_q;

  always_comb begin
    sum_x = {pxh_q, {HalfW{1'b0}}} + SumW'(pxl_q);
    sum_y = {pyh_q, {HalfW{1'b0}}} + SumW'(pyl_q);
    xg_d  = XW'({1'b0, sum_x[RecipS +: QW]}) - XW'(span_x_q[15:1]);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      xg_q <= xg_d;
      yg_q <= sum_y[RecipS +: QW];
    end
  end

  // Stage 4: pitch rotation products.
  logic signed [QW+16:0] ycs_q, ysn_q;
  logic signed [28:0]    mhs_q, mhc_q;
  logic signed [XW+12:0] fx_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ycs_q <= $signed({1'b0, yg_q}) * pitch_cos_q;
      ysn_q <= $signed({1'b0, yg_q}) * pitch_sin_q;
      mhs_q <= $signed({1'b0, mount_height_q}) * pitch_sin_q;
      mhc_q <= $signed({1'b0, mount_height_q}) * pitch_cos_q;
      fx_q  <= $signed({1'b0, focal_q}) * xg_q;
    end
  end

  // Stage 5: camera frame height and depth.
  logic signed [ZW-1:0]   yc_q, zc_q, zc6_q;
  logic signed [XW+12:0]  fx5_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      yc_q  <= ycs_q + mhs_q;
      zc_q  <= ysn_q - mhc_q;
      fx5_q <= fx_q;
    end
  end

  // Stage 6: projection numerators with the image centre folded in.
  logic signed [NW-1:0] ncol_q, nrow_q;
  logic signed [12:0]   half_w, half_h, focal_s;

  always_comb begin
    half_w  = $signed({1'b0, image_width_q[12:1]});
    half_h  = $signed({1'b0, image_height_q[12:1]});
    focal_s = $signed({1'b0, focal_q});
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ncol_q <= (fx5_q <<< 15) + half_w * zc_q;
      nrow_q <= focal_s * yc_q + half_h * zc_q;
      zc6_q  <= zc_q;
    end
  end

  // Stage 7: numerator magnitudes and the scaled divisor for the cell chain.
  logic [NW-1:0] magc_q, magr_q, div0_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      magc_q <= ncol_q[NW-1] ? NW'(-ncol_q) : NW'(ncol_q);
      magr_q <= nrow_q[NW-1] ? NW'(-nrow_q) : NW'(nrow_q);
      div0_q <= NW'({zc6_q[ZW-2:0], {(QUOT_W-1){1'b0}}});
    end
  end

  // Side band: destination indices and sign flags travel with each beat.
  always_comb begin
    side_d[1].dest_row = LastIdx - grid_y_i;
    side_d[1].dest_col = (mode_i == MODE_MIRROR) ? LastIdx - grid_x_i : grid_x_i;
    side_d[1].z_pos    = 1'b0;
    side_d[1].col_neg  = 1'b0;
    side_d[1].row_neg  = 1'b0;
    for (int k = 2; k <= NST; k++) begin
      side_d[k] = side_q[k-1];
    end
    side_d[7].z_pos   = !zc6_q[ZW-1] && (zc6_q != '0);
    side_d[7].col_neg = ncol_q[NW-1];
    side_d[7].row_neg = nrow_q[NW-1];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 1; k <= NST; k++) begin
        side_q[k] <= side_d[k];
      end
    end
  end

  // Division chains: one quotient bit per cell, overflow bit first.
  logic [NW-1:0]     remc [0:QUOT_W];
  logic [NW-1:0]     divc [0:QUOT_W];
  logic [QUOT_W-1:0] quoc [0:QUOT_W];
  logic [NW-1:0]     remr [0:QUOT_W];
  logic [NW-1:0]     divr [0:QUOT_W];
  logic [QUOT_W-1:0] quor [0:QUOT_W];

  assign remc[0] = magc_q;
  assign divc[0] = div0_q;
  assign quoc[0] = '0;
  assign remr[0] = magr_q;
  assign divr[0] = div0_q;
  assign quor[0] = '0;

  for (genvar j = 0; j < QUOT_W; j++) begin : g_cells
    gppm_div_cell #(
      .NumW  (NW),
      .QuotW (QUOT_W)
    ) u_col_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .rem_i  (remc[j]),
      .div_i  (divc[j]),
      .quot_i (quoc[j]),
      .rem_o  (remc[j+1]),
      .div_o  (divc[j+1]),
      .quot_o (quoc[j+1])
    );
    gppm_div_cell #(
      .NumW  (NW),
      .QuotW (QUOT_W)
    ) u_row_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .rem_i  (remr[j]),
      .div_i  (divr[j]),
      .quot_i (quor[j]),
      .rem_o  (remr[j+1]),
      .div_o  (divr[j+1]),
      .quot_o (quor[j+1])
    );
  end

  // Final check: in front of the camera and inside the image.
  res_t        res_d, out_q, skid_q;
  logic [11:0] qc, qr;
  logic        in_image;

  always_comb begin
    qc       = quoc[QUOT_W][QUOT_W-2:0];
    qr       = quor[QUOT_W][QUOT_W-2:0];
    in_image = side_q[NST].z_pos
            && !quoc[QUOT_W][QUOT_W-1] && !quor[QUOT_W][QUOT_W-1]
            && (!side_q[NST].col_neg || (qc == '0))
            && (!side_q[NST].row_neg || (qr == '0))
            && (13'(qc) < image_width_q) && (13'(qr) < image_height_q);
    res_d.sample_valid = in_image;
    res_d.source_col   = in_image ? qc : '0;
    res_d.source_row   = in_image ? qr : '0;
    res_d.dest_row     = side_q[NST].dest_row;
    res_d.dest_col     = side_q[NST].dest_col;
  end

  // Output register with a skid register behind it.
  assign out_free = !out_v_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      if (out_free) begin
        out_v_q <= skid_v_q || v_q[NST];
      end
      if (skid_v_q) begin
        if (out_free) begin
          skid_v_q <= 1'b0;
        end
      end else if (v_q[NST] && !out_free) begin
        skid_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_v_q ? skid_q : res_d;
    end
    if (!skid_v_q && !out_free) begin
      skid_q <= res_d;
    end
  end

  assign out_valid_o    = out_v_q;
  assign sample_valid_o = out_q.sample_valid;
  assign source_col_o   = out_q.source_col;
  assign source_row_o   = out_q.source_row;
  assign dest_row_o     = out_q.dest_row;
  assign dest_col_o     = out_q.dest_col;

  // Checks on the result and the skid control.
  `GPPM_ASSERT_IMPL(a_col_inside, clk_i, rst_ni, out_valid_o && sample_valid_o, 13'(source_col_o) < image_width_q, "valid sample column outside the image")
  `GPPM_ASSERT_IMPL(a_row_inside, clk_i, rst_ni, out_valid_o && sample_valid_o, 13'(source_row_o) < image_height_q, "valid sample row outside the image")
  `GPPM_ASSERT_IMPL(a_invalid_zero, clk_i, rst_ni, out_valid_o && !sample_valid_o, (source_col_o == '0) && (source_row_o == '0), "invalid sample with nonzero source")
  `GPPM_ASSERT_IMPL(a_skid_behind_out, clk_i, rst_ni, skid_v_q, out_v_q, "skid register full while output register empty")
  `GPPM_ASSERT_NEXT(a_accept_enters, clk_i, rst_ni, in_valid_i && !in_stall_o, v_q[1], "accepted beat missing from first stage")

endmodule

>>> sim/gppm_scoreboard.sv
// Checker for the ground plane projection mapper: watches both beat channels,
// predicts each result from the register shadow and compares it in order.
// Depends on no other file.
`timescale 1ns / 1ps

module gppm_scoreboard #(
  parameter int unsigned OUT_RES = 800
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Register shadow, kept up to date by the stimulus side.
  input  logic [15:0] cos_i,
  input  logic [15:0] sin_i,
  input  logic [11:0] focal_i,
  input  logic [12:0] width_i,
  input  logic [12:0] height_i,
  input  logic [15:0] span_x_i,
  input  logic [15:0] span_y_i,
  input  logic [11:0] mount_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [11:0] grid_x_i,
  input  logic [11:0] grid_y_i,
  input  logic        mode_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic        sample_valid_i,
  input  logic [11:0] source_col_i,
  input  logic [11:0] source_row_i,
  input  logic [11:0] dest_row_i,
  input  logic [11:0] dest_col_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic        ok;
    logic [11:0] scol;
    logic [11:0] srow;
    logic [11:0] drow;
    logic [11:0] dcol;
  } sample_t;

  sample_t pending_samples[$];

  // Projects one grid point through the pitch rotation and perspective divide.
  function automatic sample_t project(logic [11:0] gx, logic [11:0] gy, logic md);
    longint xg, yg, xc, yc, zc, cs, sn, col, row;
    sample_t s;
    cs = longint'($signed(cos_i));
    sn = longint'($signed(sin_i));
    xg = longint'((64'(gx) * 64'(span_x_i)) / OUT_RES) - longint'(span_x_i >> 1);
    yg = longint'((64'(gy) * 64'(span_y_i)) / OUT_RES);
    xc = xg * 32768;
    yc = yg * cs + longint'(mount_i) * sn;
    zc = yg * sn - longint'(mount_i) * cs;
    s = '0;
    if (zc > 0) begin
      col = (longint'(focal_i) * xc + longint'(width_i >> 1) * zc) / zc;
      row = (longint'(focal_i) * yc + longint'(height_i >> 1) * zc) / zc;
      if (col >= 0 && col < longint'(width_i) && row >= 0 && row < longint'(height_i)) begin
        s.ok = 1'b1;
        s.scol = col[11:0];
        s.srow = row[11:0];
      end
    end
    s.drow = 12'(OUT_RES - 1) - gy;
    s.dcol = (md == 1'b1) ? 12'(OUT_RES - 1) - gx : gx;
    return s;
  endfunction

  // Prints one line per mismatch and counts it.
  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    fail_count_o++;
  endtask

  assign pending_o = pending_samples.size();

  initial fail_count_o = 0;

  // Predict on accepted input beats, compare on accepted output beats.
  always @(posedge clk_i) begin
    sample_t w;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) pending_samples.push_back(project(grid_x_i, grid_y_i, mode_i));
      if (out_valid_i && !out_stall_i) begin
        if (pending_samples.size() == 0) begin
          report_mismatch("unexpected beat", 1, 0);
        end else begin
          w = pending_samples.pop_front();
          if (sample_valid_i !== w.ok) report_mismatch("sample_valid", sample_valid_i, w.ok);
          if (source_col_i !== w.scol) report_mismatch("source_col", source_col_i, w.scol);
          if (source_row_i !== w.srow) report_mismatch("source_row", source_row_i, w.srow);
          if (dest_row_i !== w.drow) report_mismatch("dest_row", dest_row_i, w.drow);
          if (dest_col_i !== w.dcol) report_mismatch("dest_col", dest_col_i, w.dcol);
        end
      end
    end
  end

endmodule

>>> sim/tb_ground_plane_projection_mapper_unit.sv
// Testbench top for the ground plane projection mapper: drives grid beats and
// register writes, stalls the output at random and gives the verdict.
// Depends on gppm_pkg, the mapper RTL and gppm_scoreboard.
`timescale 1ns / 1ps

module tb_ground_plane_projection_mapper_unit;
  import gppm_pkg::*;

  localparam int unsigned RES = 800;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 40;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0, in_stall_o;
  logic [11:0] grid_x_i = '0, grid_y_i = '0;
  logic mode_i = 1'b0;
  logic out_valid_o, out_stall_i = 1'b0;
  logic sample_valid_o;
  logic [11:0] source_col_o, source_row_o, dest_row_o, dest_col_o;

  // Shadow of the register file as the predictor sees it.
  logic [15:0] cos_q = PITCH_COS_RESET, sin_q = PITCH_SIN_RESET;
  logic [11:0] focal_q = FOCAL_SCALE_RESET, mount_q = MOUNT_HEIGHT_RESET;
  logic [12:0] width_q = IMAGE_WIDTH_RESET, height_q = IMAGE_HEIGHT_RESET;
  logic [15:0] span_x_q = GROUND_SPAN_X_RESET, span_y_q = GROUND_SPAN_Y_RESET;

  int fail_count, pending, cycles;
  int out_wait = 0;

  always #1 clk_i = ~clk_i;

  ground_plane_projection_mapper_unit #(.OUT_RES(RES)) dut (.*);

  gppm_scoreboard #(.OUT_RES(RES)) u_scoreboard (
    .clk_i, .rst_ni, .cos_i(cos_q), .sin_i(sin_q), .focal_i(focal_q),
    .width_i(width_q), .height_i(height_q), .span_x_i(span_x_q),
    .span_y_i(span_y_q), .mount_i(mount_q), .in_valid_i, .in_stall_i(in_stall_o),
    .grid_x_i, .grid_y_i, .mode_i, .out_valid_i(out_valid_o), .out_stall_i,
    .sample_valid_i(sample_valid_o), .source_col_i(source_col_o),
    .source_row_i(source_row_o), .dest_row_i(dest_row_o), .dest_col_i(dest_col_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end
  initial cycles = 0;

  // The receiver draws a random wait for each accepted result beat.
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) out_wait <= $urandom_range(0, 3);
  end

  // The stall stays high until the drawn wait has passed with a beat waiting.
  always @(negedge clk_i) begin
    if (out_wait > 0) begin
      out_stall_i <= 1'b1;
      if (out_valid_o) out_wait <= out_wait - 1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Register write in a setup and an access phase; updates the shadow after the access phase.
  task automatic write_reg(gppm_reg_e idx, logic [31:0] val);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= 5'(4 * int'(idx)); pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_PITCH_COS:    cos_q = val[15:0];
      REG_PITCH_SIN:    sin_q = val[15:0];
      REG_FOCAL_SCALE:  focal_q = val[11:0];
      REG_IMAGE_WIDTH:  width_q = val[12:0];
      REG_IMAGE_HEIGHT: height_q = val[12:0];
      REG_SPAN_X:       span_x_q = val[15:0];
      REG_SPAN_Y:       span_y_q = val[15:0];
      REG_MOUNT_HEIGHT: mount_q = val[11:0];
      default: ;
    endcase
  endtask

  // Sends one grid beat after a random gap; holds it until accepted.
  task automatic send_grid(logic [11:0] gx, logic [11:0] gy, logic md, bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 3) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1; grid_x_i <= gx; grid_y_i <= gy; mode_i <= md;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic drain_all();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Random raster-like grid points; mostly within OUT_RES, some anywhere.
  task automatic random_phase(int count, bit gaps);
    logic [11:0] gx, gy;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) < 8) begin
        gx = 12'($urandom_range(0, RES - 1));
        gy = 12'($urandom_range(0, RES - 1));
      end else begin
        gx = 12'($urandom);
        gy = 12'($urandom);
      end
      send_grid(gx, gy, 1'($urandom), gaps && ($urandom_range(0, 3) != 0));
    end
  endtask

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: grid corners, both modes, behind the camera and far out.
    send_grid(12'd0, 12'd0, 1'b0, 1'b0);
    send_grid(12'd799, 12'd799, 1'b1, 1'b0);
    send_grid(12'd400, 12'd400, 1'b0, 1'b0);
    send_grid(12'd400, 12'd0, 1'b1, 1'b0);
    send_grid(12'hFFF, 12'hFFF, 1'b1, 1'b0);
    send_grid(12'hFFF, 12'd0, 1'b0, 1'b0);
    send_grid(12'd0, 12'hFFF, 1'b1, 1'b0);
    send_grid(12'hAAA, 12'h555, 1'b0, 1'b0);
    send_grid(12'h555, 12'hAAA, 1'b1, 1'b0);
    random_phase(60, 1'b1);
    // The sender holds off until every result is back.
    drain_all();

    // Extremes: maximum registers, then minimum values with a zero-width image.
    write_reg(REG_PITCH_COS, 32'h0000_7FFF);
    write_reg(REG_PITCH_SIN, 32'h0000_8000);
    write_reg(REG_FOCAL_SCALE, 32'd4095);
    write_reg(REG_IMAGE_WIDTH, 32'd4096);
    write_reg(REG_IMAGE_HEIGHT, 32'd4096);
    write_reg(REG_SPAN_X, 32'hFFFF);
    write_reg(REG_SPAN_Y, 32'hFFFF);
    write_reg(REG_MOUNT_HEIGHT, 32'd4095);
    random_phase(60, 1'b1);
    drain_all();

    write_reg(REG_PITCH_COS, 32'h0000_8000);
    write_reg(REG_PITCH_SIN, 32'h0000_7FFF);
    write_reg(REG_FOCAL_SCALE, 32'd0);
    write_reg(REG_IMAGE_WIDTH, 32'd0);
    write_reg(REG_IMAGE_HEIGHT, 32'd1);
    write_reg(REG_SPAN_X, 32'd0);
    write_reg(REG_SPAN_Y, 32'd0);
    write_reg(REG_MOUNT_HEIGHT, 32'd0);
    random_phase(40, 1'b0);
    drain_all();

    // Random settings, biased towards a downward-looking camera.
    for (int k = 0; k < 4; k++) begin
      write_reg(REG_PITCH_COS, 32'($signed(-$urandom_range(0, 32768))));
      write_reg(REG_PITCH_SIN, 32'($urandom_range(0, 32767)));
      write_reg(REG_FOCAL_SCALE, 32'($urandom_range(0, 4095)));
      write_reg(REG_IMAGE_WIDTH, 32'($urandom_range(1, 4096)));
      write_reg(REG_IMAGE_HEIGHT, 32'($urandom_range(1, 4096)));
      write_reg(REG_SPAN_X, 32'($urandom_range(0, 65535)));
      write_reg(REG_SPAN_Y, 32'($urandom_range(0, 65535)));
      write_reg(REG_MOUNT_HEIGHT, 32'($urandom_range(0, 4095)));
      random_phase(60, 1'b1);
      drain_all();
    end

    // Back to the reset calibration, which yields many in-image samples.
    write_reg(REG_PITCH_COS, 32'($signed(PITCH_COS_RESET)));
    write_reg(REG_PITCH_SIN, 32'(PITCH_SIN_RESET));
    write_reg(REG_FOCAL_SCALE, 32'(FOCAL_SCALE_RESET));
    write_reg(REG_IMAGE_WIDTH, 32'(IMAGE_WIDTH_RESET));
    write_reg(REG_IMAGE_HEIGHT, 32'(IMAGE_HEIGHT_RESET));
    write_reg(REG_SPAN_X, 32'(GROUND_SPAN_X_RESET));
    write_reg(REG_SPAN_Y, 32'(GROUND_SPAN_Y_RESET));
    write_reg(REG_MOUNT_HEIGHT, 32'(MOUNT_HEIGHT_RESET));
    random_phase(40, 1'b1);
    drain_all();

    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
